### hdl/hta_pkg.sv
// Shared types and constants of the heater thermostat with adaptive wait.
package hta_pkg;

    localparam int TEMP_W    = 8;
    localparam int SP_W      = 8;
    localparam int OFS_W     = 4;
    localparam int STEP_W    = 4;
    localparam int MIN_W     = 7;
    localparam int SEC_W     = 6;
    localparam int TARGET_W  = 10;

    localparam logic [SEC_W-1:0] SEC_LAST     = SEC_W'(59);
    localparam logic [MIN_W-1:0] MIN_SAT      = MIN_W'(127);
    localparam logic [MIN_W-1:0] WAIT_RESET   = MIN_W'(4);

    localparam logic [SP_W-1:0]   CAP_RESET    = SP_W'(60);
    localparam logic [OFS_W-1:0]  OFS_RESET    = OFS_W'(3);
    localparam logic [STEP_W-1:0] STEP_RESET   = STEP_W'(3);
    localparam logic [MIN_W-1:0]  MAX_RESET    = MIN_W'(101);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SETPOINT_RAW    = 3'd0,
        CFG_SETPOINT_CAP    = 3'd1,
        CFG_SETPOINT_OFFSET = 3'd2,
        CFG_WAIT_STEP       = 3'd3,
        CFG_WAIT_MAX        = 3'd4
    } cfg_addr_e;

    typedef enum logic [1:0] {
        REQ_STEP  = 2'd0,
        REQ_START = 2'd1,
        REQ_RESET = 2'd2,
        REQ_NONE  = 2'd3
    } req_e;

    typedef struct packed {
        logic [SP_W-1:0]   setpoint_raw;
        logic [SP_W-1:0]   setpoint_cap;
        logic [OFS_W-1:0]  setpoint_offset;
        logic [STEP_W-1:0] wait_step;
        logic [MIN_W-1:0]  wait_max;
    } hta_cfg_t;

    typedef struct packed {
        req_e                     req_type;
        logic signed [TEMP_W-1:0] temperature;
        logic                     second_tick;
        logic                     standby_active;
        logic                     heat_enabled;
        logic                     show_mode;
        logic                     error_active;
        logic                     error_override;
        logic                     start_delay_clear;
        logic                     fan_hold_clear;
    } hta_item_t;

    typedef struct packed {
        logic              heat_on;
        logic              fan_request;
        logic              start_delay;
        logic              fan_hold;
        logic              second_pending;
        logic [SEC_W-1:0]  seconds_count;
        logic [MIN_W-1:0]  off_minutes;
        logic [MIN_W-1:0]  wait_limit;
        logic              heater_level;
        logic              fan_level;
    } hta_state_t;

endpackage

### hdl/hta_step.sv
// Next-state logic of the controller for one item.
module hta_step (
    input  hta_pkg::hta_cfg_t   cfg,
    input  hta_pkg::hta_item_t  item,
    input  hta_pkg::hta_state_t cur,
    output hta_pkg::hta_state_t nxt
);
    import hta_pkg::*;

    always_comb begin
        hta_state_t            s;
        logic [SP_W:0]         target;
        logic signed [TARGET_W-1:0] target_s;
        logic signed [TARGET_W-1:0] temp_s;
        logic [SEC_W:0]        sec_inc;
        logic [MIN_W:0]        wait_sum;

        s = cur;
        // apply the latches before the request
        if (item.second_tick)       s.second_pending = 1'b1;
        if (item.start_delay_clear) s.start_delay    = 1'b0;
        if (item.fan_hold_clear)    s.fan_hold       = 1'b0;

        if (cfg.setpoint_raw >= cfg.setpoint_cap) begin
            target = {1'b0, cfg.setpoint_cap};
        end else begin
            target = {1'b0, cfg.setpoint_raw} + (SP_W+1)'(cfg.setpoint_offset);
        end
        target_s = signed'({1'b0, target});
        temp_s   = TARGET_W'(item.temperature);
        sec_inc  = {1'b0, s.seconds_count} + (SEC_W+1)'(1);
        wait_sum = {1'b0, s.wait_limit} + (MIN_W+1)'(cfg.wait_step);

        case (item.req_type)
            REQ_STEP: begin
                if (item.error_override && item.standby_active) begin
                    s.fan_level   = 1'b0;
                    s.fan_hold    = 1'b0;
                    s.start_delay = 1'b0;
                end else if (!item.standby_active || !item.heat_enabled ||
                             item.show_mode || item.error_active) begin
                    s.heater_level = 1'b0;
                    s.fan_request  = 1'b0;
                    s.heat_on      = 1'b0;
                    s.start_delay  = 1'b0;
                    if (!s.fan_hold) s.fan_level = 1'b0;
                end else begin
                    if (target_s > temp_s) begin
                        if (!s.heat_on) begin
                            s.fan_request = 1'b0;
                            s.start_delay = 1'b1;
                            s.heat_on     = 1'b1;
                            s.wait_limit  = '0;
                        end
                        s.off_minutes   = '0;
                        s.seconds_count = '0;
                    end else if (!(target_s == temp_s && s.heat_on) && s.second_pending) begin
                        s.second_pending = 1'b0;
                        if (sec_inc <= (SEC_W+1)'(SEC_LAST)) begin
                            s.seconds_count = sec_inc[SEC_W-1:0];
                        end else begin
                            s.seconds_count = '0;
                            if (s.off_minutes < MIN_SAT) s.off_minutes = s.off_minutes + 1'b1;
                            // off-time reached: stop heating, then grow the limit a minute later
                            if (s.off_minutes >= s.wait_limit) begin
                                s.fan_request = 1'b1;
                                s.heat_on     = 1'b0;
                                if (s.off_minutes > s.wait_limit) begin
                                    if (wait_sum >= {1'b0, cfg.wait_max}) begin
                                        s.wait_limit = cfg.wait_max;
                                    end else begin
                                        s.wait_limit = wait_sum[MIN_W-1:0];
                                    end
                                    s.fan_request = 1'b0;
                                    s.off_minutes = '0;
                                end
                            end
                        end
                    end
                    // drive the outputs from the updated flags
                    if (s.heat_on) begin
                        if (!s.start_delay) s.heater_level = 1'b1;
                        s.fan_level = 1'b1;
                        s.fan_hold  = 1'b1;
                    end else begin
                        s.heater_level = 1'b0;
                        if (s.fan_request)   s.fan_level = 1'b1;
                        else if (!s.fan_hold) s.fan_level = 1'b0;
                        s.start_delay = 1'b0;
                    end
                end
            end
            REQ_START: begin
                s.start_delay   = 1'b1;
                s.heat_on       = 1'b1;
                s.wait_limit    = '0;
                s.off_minutes   = (cfg.wait_step != '0) ?
                                  MIN_W'(cfg.wait_step - 1'b1) : '0;
                s.seconds_count = '0;
                s.fan_request   = 1'b0;
            end
            REQ_RESET: begin
                s.heat_on       = 1'b0;
                s.off_minutes   = '0;
                s.seconds_count = '0;
                s.wait_limit    = MIN_W'(cfg.wait_step);
            end
            default: begin
            end
        endcase
        nxt = s;
    end

endmodule

### hdl/heater_thermostat_adaptive_wait_top.sv
// Top level of the heater and fan thermostat with adaptive wait limit.
// One item per clock is sustained while results are taken: an item is taken into an
// input register, its whole control step is worked out combinationally against the
// controller state, and the result goes to an output register. The input stage stalls
// only while the output register is full and not taken. Configuration is written
// through the plain write port; the user must write it only while the block is idle,
// which the block itself does not enforce. The register index follows the order
// setpoint_raw, setpoint_cap, setpoint_offset, wait_step, wait_max.
module heater_thermostat_adaptive_wait_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [hta_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [hta_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // temperature[7:0], second_tick, standby_active, heat_enabled, show_mode,
    // error_active, error_override, start_delay_clear, fan_hold_clear
    input  logic [15:0]                   s_tdata,
    // req_type[1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // heater_drive, fan_drive, heat_request, wait_limit_now[6:0], zero fill
    output logic [15:0]                   m_tdata
);
    import hta_pkg::*;

    hta_cfg_t   cfg_reg;
    hta_item_t  item_reg;
    hta_state_t state_reg;
    hta_state_t state_next;
    logic       in_valid_reg;
    logic       out_valid_reg;
    logic [15:0] out_data_reg;
    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    hta_step u_step (
        .cfg  (cfg_reg),
        .item (item_reg),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setpoint_raw    <= '0;
            cfg_reg.setpoint_cap    <= CAP_RESET;
            cfg_reg.setpoint_offset <= OFS_RESET;
            cfg_reg.wait_step       <= STEP_RESET;
            cfg_reg.wait_max        <= MAX_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SETPOINT_RAW:    cfg_reg.setpoint_raw    <= cfg_wdata;
                CFG_SETPOINT_CAP:    cfg_reg.setpoint_cap    <= cfg_wdata;
                CFG_SETPOINT_OFFSET: cfg_reg.setpoint_offset <= cfg_wdata[OFS_W-1:0];
                CFG_WAIT_STEP:       cfg_reg.wait_step       <= cfg_wdata[STEP_W-1:0];
                CFG_WAIT_MAX:        cfg_reg.wait_max        <= cfg_wdata[MIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input stage: load on accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.req_type          <= req_e'(s_tuser);
            item_reg.temperature       <= signed'(s_tdata[7:0]);
            item_reg.second_tick       <= s_tdata[8];
            item_reg.standby_active    <= s_tdata[9];
            item_reg.heat_enabled      <= s_tdata[10];
            item_reg.show_mode         <= s_tdata[11];
            item_reg.error_active      <= s_tdata[12];
            item_reg.error_override    <= s_tdata[13];
            item_reg.start_delay_clear <= s_tdata[14];
            item_reg.fan_hold_clear    <= s_tdata[15];
        end
    end

    // commit state and result together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{heat_on: 1'b0, fan_request: 1'b0, start_delay: 1'b0,
                           fan_hold: 1'b0, second_pending: 1'b0, seconds_count: '0,
                           off_minutes: '0, wait_limit: WAIT_RESET,
                           heater_level: 1'b0, fan_level: 1'b0};
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {6'd0, state_next.wait_limit, state_next.heat_on,
                             state_next.fan_level, state_next.heater_level};
        end
    end

    a_sec_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.seconds_count <= SEC_LAST)
        else $error("seconds count out of range");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(item_reg))
        else $error("stalled item lost or changed");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("finished item not presented");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("state changed without an item");

endmodule
